[design/fpalu_pkg.sv]
// Shared types, codes and helpers of the Q24.8 fixed-point ALU.
// Used by the front, queue, back and top-level modules; depends on nothing.
package fpalu_pkg;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_INC  = 4'd6,
        OP_ITOF = 4'd7,
        OP_FTOI = 4'd8,
        OP_NONE = 4'd9
    } t_op;

    // One classified word as it waits in the queue.
    typedef struct packed {
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        logic        eq;
        logic        lt;
        logic        gt;
    } t_entry;

    // Result and status that travel down the back-end pipeline.
    typedef struct packed {
        t_op         op;
        logic        neg;
        logic        eq;
        logic        lt;
        logic        gt;
        logic        ovf;
        logic        dz;
        logic [31:0] res;
    } t_pay;

    typedef struct packed {
        logic [31:0] res;
        logic        ovf;
    } t_sat;

    // Applies a sign to an unsigned magnitude and saturates to 32 bits.
    function automatic t_sat sat_mag(input logic [63:0] mag, input logic neg);
        t_sat s;
        s.ovf = 1'b0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                s.res = WORD_MIN;
                s.ovf = 1'b1;
            end else begin
                s.res = 32'd0 - mag[31:0];
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                s.res = WORD_MAX;
                s.ovf = 1'b1;
            end else begin
                s.res = mag[31:0];
            end
        end
        return s;
    endfunction

endpackage

[design/fpalu_front.sv]
// Front end of the fixed-point ALU: input handshake, opcode decode and compares.
// Depends on fpalu_pkg; feeds fpalu_queue.
module fpalu_front (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [3:0]            i_command,
    input  logic signed [31:0]    i_operand_a,
    input  logic signed [31:0]    i_operand_b,
    input  logic                  i_full,
    output logic                  o_push,
    output fpalu_pkg::t_entry     o_ent
);

    fpalu_pkg::t_op op;

    always_comb begin
        case (i_command)
            fpalu_pkg::OP_ADD, fpalu_pkg::OP_SUB, fpalu_pkg::OP_MUL,
            fpalu_pkg::OP_DIV, fpalu_pkg::OP_MIN, fpalu_pkg::OP_MAX,
            fpalu_pkg::OP_INC, fpalu_pkg::OP_ITOF, fpalu_pkg::OP_FTOI: begin
                op = fpalu_pkg::t_op'(i_command);
            end
            default: begin
                op = fpalu_pkg::OP_NONE;
            end
        endcase
    end

    assign o_ready   = !i_full;
    assign o_push    = i_valid && !i_full;
    assign o_ent.op  = op;
    assign o_ent.a   = i_operand_a;
    assign o_ent.b   = i_operand_b;
    assign o_ent.eq  = (i_operand_a == i_operand_b);
    assign o_ent.lt  = (i_operand_a < i_operand_b);
    assign o_ent.gt  = (i_operand_a > i_operand_b);

endmodule

[design/fpalu_queue.sv]
// Two-entry queue that decouples the ALU front end from its pipelined back end.
// Depends on fpalu_pkg for the entry type.
module fpalu_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fpalu_pkg::t_entry i_ent,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_nonempty,
    output fpalu_pkg::t_entry o_ent
);

    fpalu_pkg::t_entry r_mem [0:1];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_ent      = r_mem[r_rp];

endmodule

[design/fpalu_back.sv]
// Back end of the fixed-point ALU: operand stage, multiplier, one-bit-per-stage
// divider and rounding/saturation, all under one stall enable. Depends on fpalu_pkg.
module fpalu_back #(
    parameter int FRACTION_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fpalu_pkg::t_entry  i_ent,
    input  logic               i_ent_valid,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result,
    output logic               o_is_equal,
    output logic               o_is_less,
    output logic               o_is_greater,
    output logic               o_divide_by_zero,
    output logic               o_overflowed
);

    // The rounded quotient is floor((2n + d) / 2d), n = |a| << FRACTION_BITS.
    localparam int NW = 33 + FRACTION_BITS;

    logic               ce;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [32:0] sum33;
    logic signed [32:0] dif33;
    logic [31+FRACTION_BITS:0] shl;
    logic               shl_ok;
    fpalu_pkg::t_pay    n_p1;
    fpalu_pkg::t_pay    n_pm;
    fpalu_pkg::t_pay    n_out;
    fpalu_pkg::t_sat    msat;
    fpalu_pkg::t_sat    dsat;

    fpalu_pkg::t_pay    r_p1;
    logic [31:0]        r_ma;
    logic [31:0]        r_mb;
    logic               r_v1;
    logic [63:0]        r_prod;
    fpalu_pkg::t_pay    r_dp  [0:NW];
    logic [NW-1:0]      r_num [0:NW];
    logic [32:0]        r_rem [0:NW];
    logic [32:0]        r_den [0:NW];
    logic [NW:0]        r_dv;
    fpalu_pkg::t_pay    r_out;
    logic               r_ov;

    assign ce    = !r_ov || i_ready;
    assign o_pop = ce && i_ent_valid;

    assign a      = i_ent.a;
    assign b      = i_ent.b;
    assign sum33  = {a[31], a} + {b[31], b};
    assign dif33  = {a[31], a} - {b[31], b};
    assign shl    = {{FRACTION_BITS{a[31]}}, a} << FRACTION_BITS;
    assign shl_ok = (&shl[31+FRACTION_BITS:31]) || !(|shl[31+FRACTION_BITS:31]);

    always_comb begin
        n_p1.op  = i_ent.op;
        n_p1.neg = a[31] ^ b[31];
        n_p1.eq  = i_ent.eq;
        n_p1.lt  = i_ent.lt;
        n_p1.gt  = i_ent.gt;
        n_p1.ovf = 1'b0;
        n_p1.dz  = 1'b0;
        n_p1.res = 32'd0;
        case (i_ent.op)
            fpalu_pkg::OP_ADD: begin
                n_p1.ovf = sum33[32] ^ sum33[31];
                n_p1.res = n_p1.ovf ? (sum33[32] ? fpalu_pkg::WORD_MIN : fpalu_pkg::WORD_MAX)
                                    : sum33[31:0];
            end
            fpalu_pkg::OP_SUB: begin
                n_p1.ovf = dif33[32] ^ dif33[31];
                n_p1.res = n_p1.ovf ? (dif33[32] ? fpalu_pkg::WORD_MIN : fpalu_pkg::WORD_MAX)
                                    : dif33[31:0];
            end
            fpalu_pkg::OP_MIN: begin
                n_p1.res = i_ent.gt ? b : a;
            end
            fpalu_pkg::OP_MAX: begin
                n_p1.res = i_ent.gt ? a : b;
            end
            fpalu_pkg::OP_INC: begin
                n_p1.ovf = (a == fpalu_pkg::WORD_MAX);
                n_p1.res = n_p1.ovf ? fpalu_pkg::WORD_MAX : a + 32'sd1;
            end
            fpalu_pkg::OP_ITOF: begin
                n_p1.ovf = !shl_ok;
                n_p1.res = shl_ok ? shl[31:0]
                                  : (a[31] ? fpalu_pkg::WORD_MIN : fpalu_pkg::WORD_MAX);
            end
            fpalu_pkg::OP_FTOI: begin
                n_p1.res = a >>> FRACTION_BITS;
            end
            fpalu_pkg::OP_DIV: begin
                n_p1.dz = (b == 32'sd0);
            end
            default: begin
                n_p1.res = 32'd0;
            end
        endcase
    end

    // Operand stage: magnitudes for the multiplier and the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ce) begin
            r_v1 <= i_ent_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p1 <= n_p1;
            r_ma <= a[31] ? 32'd0 - a : a;
            r_mb <= b[31] ? 32'd0 - b : b;
        end
    end

    // Multiplier stage and divider setup.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_prod   <= r_ma * r_mb;
            r_dp[0]  <= r_p1;
            r_num[0] <= NW'({r_ma, {FRACTION_BITS{1'b0}}, 1'b0}) + NW'(r_mb);
            r_den[0] <= {r_mb, 1'b0};
            r_rem[0] <= 33'd0;
        end
    end

    // Rounds the product half away from zero on the first divider stage.
    always_comb begin
        msat = fpalu_pkg::sat_mag((r_prod + 64'(1 << (FRACTION_BITS - 1))) >> FRACTION_BITS,
                                  r_dp[0].neg);
        n_pm = r_dp[0];
        if (r_dp[0].op == fpalu_pkg::OP_MUL) begin
            n_pm.res = msat.res;
            n_pm.ovf = msat.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (ce) begin
            r_dv[0] <= r_v1;
        end
    end

    for (genvar j = 1; j <= NW; j++) begin : g_div
        logic [33:0] t;
        logic [33:0] diff;
        logic        ge;

        assign t    = {r_rem[j-1], r_num[j-1][NW-1]};
        assign ge   = (t >= {1'b0, r_den[j-1]});
        assign diff = t - {1'b0, r_den[j-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j] <= 1'b0;
            end else if (ce) begin
                r_dv[j] <= r_dv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_rem[j] <= ge ? diff[32:0] : t[32:0];
                r_num[j] <= {r_num[j-1][NW-2:0], ge};
                r_den[j] <= r_den[j-1];
                r_dp[j]  <= (j == 1) ? n_pm : r_dp[j-1];
            end
        end
    end

    always_comb begin
        dsat  = fpalu_pkg::sat_mag(64'(r_num[NW]), r_dp[NW].neg);
        n_out = r_dp[NW];
        if (r_dp[NW].op == fpalu_pkg::OP_DIV) begin
            n_out.res = r_dp[NW].dz ? 32'd0 : dsat.res;
            n_out.ovf = r_dp[NW].dz ? 1'b0 : dsat.ovf;
        end
    end

    // Output register; it holds its word while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (ce) begin
            r_ov <= r_dv[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_ov;
    assign o_result         = r_out.res;
    assign o_is_equal       = r_out.eq;
    assign o_is_less        = r_out.lt;
    assign o_is_greater     = r_out.gt;
    assign o_divide_by_zero = r_out.dz;
    assign o_overflowed     = r_out.ovf;

endmodule

[design/fixed_point_alu_q24_8_core.sv]
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on fpalu_pkg, fpalu_front, fpalu_queue and fpalu_back.
//
// Input channel: i_valid / o_ready with i_command, i_operand_a, i_operand_b.
// Output channel: o_valid / i_ready with o_result and five status flags.
// A word is taken on any edge where valid and ready are both high.
//
// The front end decodes the opcode and computes the compare flags, then the
// word waits in a two-entry queue. The back end is one pipeline for every
// opcode: an operand stage, a multiplier stage, FRACTION_BITS + 33 divider
// stages of one quotient bit each, and the output register. While i_ready
// stays high, one word per cycle is accepted and delivered; the divider's
// depth sets the latency.
//
// When i_ready is low while a word waits at the output, the whole back end
// holds; o_ready drops once both queue entries are occupied. Reset empties
// the queue and clears all valid flags; data registers are not reset.
module fixed_point_alu_q24_8_core #(
    parameter int FRACTION_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [3:0]         i_command,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_result,
    output logic               o_is_equal,
    output logic               o_is_less,
    output logic               o_is_greater,
    output logic               o_divide_by_zero,
    output logic               o_overflowed
);

    fpalu_pkg::t_entry push_ent;
    fpalu_pkg::t_entry head_ent;
    logic              push;
    logic              pop;
    logic              full;
    logic              nonempty;

    fpalu_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_full      (full),
        .o_push      (push),
        .o_ent       (push_ent)
    );

    fpalu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_ent      (push_ent),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_ent      (head_ent)
    );

    fpalu_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ent            (head_ent),
        .i_ent_valid      (nonempty),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result         (o_result),
        .o_is_equal       (o_is_equal),
        .o_is_less        (o_is_less),
        .o_is_greater     (o_is_greater),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflowed     (o_overflowed)
    );

endmodule

[design/fpalu_checker.sv]
// Port-level checks for the fixed-point ALU output channel.
// Bound to fixed_point_alu_q24_8_core; depends on nothing else.
module fpalu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_ready,
    input logic        o_valid,
    input logic [31:0] o_result,
    input logic        o_is_equal,
    input logic        o_is_less,
    input logic        o_is_greater,
    input logic        o_divide_by_zero,
    input logic        o_overflowed
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("output word changed while stalled");

    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_is_equal, o_is_less, o_is_greater}) == 1)
        else $error("compare flags not exclusive");

    a_dz_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_divide_by_zero && o_overflowed))
        else $error("zero divisor reported with overflow");

    a_dz_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_result == 32'd0)
        else $error("zero divisor gave nonzero result");

endmodule

bind fixed_point_alu_q24_8_core fpalu_checker u_fpalu_checker (.*);

[tb/fixed_point_alu_q24_8_core_test.sv]
// Testbench for the Q24.8 fixed-point ALU core: random and directed words with a predictor.
// Depends on fpalu_pkg and fixed_point_alu_q24_8_core.
`timescale 1ns / 1ps

class alu_scoreboard;
    typedef struct {
        logic [31:0] res;
        logic        eq, lt, gt, dz, ovf;
    } t_expected;

    t_expected pending[$];
    int        mismatches;
    int        checked;

    function logic [31:0] saturate(input logic signed [65:0] v, output logic ovf);
        ovf = 1'b0;
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function void note_word(input logic [3:0] cmd, input logic signed [31:0] a,
                            input logic signed [31:0] b);
        t_expected e;
        logic [63:0] ma, mb, p, q;
        logic neg;
        ma  = a < 0 ? 64'(-(65'(a))) : 64'(a);
        mb  = b < 0 ? 64'(-(65'(b))) : 64'(b);
        neg = (a < 0) != (b < 0);
        e.eq = a == b; e.lt = a < b; e.gt = a > b;
        e.dz = 1'b0; e.ovf = 1'b0; e.res = '0;
        case (cmd)
            fpalu_pkg::OP_ADD: e.res = saturate(66'(a) + 66'(b), e.ovf);
            fpalu_pkg::OP_SUB: e.res = saturate(66'(a) - 66'(b), e.ovf);
            fpalu_pkg::OP_MUL: begin
                p = ma * mb;
                q = (p + 64'd128) >> 8;
                e.res = saturate(neg ? -$signed({2'b0, q}) : $signed({2'b0, q}), e.ovf);
            end
            fpalu_pkg::OP_DIV: begin
                if (b == 0) begin
                    e.dz = 1'b1;
                end else begin
                    q = (2 * (ma << 8) + mb) / (2 * mb);
                    e.res = saturate(neg ? -$signed({2'b0, q}) : $signed({2'b0, q}), e.ovf);
                end
            end
            fpalu_pkg::OP_MIN:  e.res = (a > b) ? b : a;
            fpalu_pkg::OP_MAX:  e.res = (b < a) ? a : b;
            fpalu_pkg::OP_INC:  e.res = saturate(66'(a) + 66'sd1, e.ovf);
            fpalu_pkg::OP_ITOF: e.res = saturate(66'(a) * 66'sd256, e.ovf);
            fpalu_pkg::OP_FTOI: e.res = a >>> 8;
            default: ;
        endcase
        pending.push_back(e);
    endfunction

    function void check_word(input logic [31:0] res, input logic eq, lt, gt, dz, ovf);
        t_expected e;
        checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result word %h", res);
            return;
        end
        e = pending.pop_front();
        if (e.res !== res || e.eq !== eq || e.lt !== lt || e.gt !== gt
                || e.dz !== dz || e.ovf !== ovf) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"ERROR: exp res=%h eq%b lt%b gt%b dz%b ov%b, ",
                          "got res=%h eq%b lt%b gt%b dz%b ov%b"},
                         e.res, e.eq, e.lt, e.gt, e.dz, e.ovf, res, eq, lt, gt, dz, ovf);
        end
    endfunction
endclass

module fixed_point_alu_q24_8_core_test;

    localparam int LATENCY  = 44;
    localparam int WATCHDOG = 5000;
    localparam int N_RANDOM = 1430;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [3:0]         i_command = '0;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_result;
    logic               o_is_equal, o_is_less, o_is_greater, o_divide_by_zero, o_overflowed;

    alu_scoreboard board = new();
    bit  calm = 1'b0;
    int  idle_cycles = 0;
    int  accepted = 0;

    fixed_point_alu_q24_8_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Sampling at the rising edge; the scoreboard sees both channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                board.note_word(i_command, i_operand_a, i_operand_b);
                accepted++;
            end
            if (o_valid && i_ready)
                board.check_word(o_result, o_is_equal, o_is_less, o_is_greater,
                                 o_divide_by_zero, o_overflowed);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("Timeout: no handshake for %0d cycles", WATCHDOG);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver stalls in random bursts until the final calm stretch.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function logic signed [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 0;
            3: return $signed(32'($urandom_range(0, 2047))) - 1024;
            4, 5: return $signed(32'($urandom_range(0, 32'h0003_FFFF))) - 32'sh0002_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_word(input logic [3:0] cmd, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        i_command   <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [3:0] cmd;
        logic signed [31:0] a, b;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every opcode, range ends, zero divisor, unused opcodes.
        send_word(fpalu_pkg::OP_ADD, 32'sh7FFF_FFFF, 32'sh0000_0001);
        send_word(fpalu_pkg::OP_SUB, 32'sh8000_0000, 32'sh0000_0001);
        send_word(fpalu_pkg::OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
        send_word(fpalu_pkg::OP_MUL, 32'sh0000_0180, -32'sh0000_0080);
        send_word(fpalu_pkg::OP_MUL, 32'sh0000_0001, 32'sh0000_0080);
        send_word(fpalu_pkg::OP_DIV, 32'sh0000_0100, 32'sh0000_0000);
        send_word(fpalu_pkg::OP_DIV, 32'sh8000_0000, 32'sh0000_0001);
        send_word(fpalu_pkg::OP_DIV, 32'sh8000_0000, -32'sh0000_0001);
        send_word(fpalu_pkg::OP_DIV, -32'sh0000_0001, 32'sh0000_0200);
        send_word(fpalu_pkg::OP_MIN, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(fpalu_pkg::OP_MAX, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(fpalu_pkg::OP_MIN, 32'sh0000_0005, 32'sh0000_0005);
        send_word(fpalu_pkg::OP_INC, 32'sh7FFF_FFFF, 0);
        send_word(fpalu_pkg::OP_INC, -32'sh0000_0001, 0);
        send_word(fpalu_pkg::OP_ITOF, 32'sh0080_0000, 0);
        send_word(fpalu_pkg::OP_ITOF, -32'sh0080_0001, 0);
        send_word(fpalu_pkg::OP_FTOI, -32'sh0000_0001, 0);
        send_word(fpalu_pkg::OP_FTOI, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(fpalu_pkg::OP_NONE, 32'sh1234_5678, 32'sh1234_5678);
        send_word(4'd15, 32'shFFFF_FFFF, 32'sh0000_0000);
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) drain();
            if (i == N_RANDOM - 200) calm = 1'b1;
            cmd = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            a = pick_operand();
            b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
            send_word(cmd, a, b);
        end
        i_valid <= 1'b0;

        fork
            while (board.pending.size() != 0) @(negedge i_clk);
            begin
                repeat (LATENCY * 200) @(negedge i_clk);
                $display("Timeout waiting for outstanding results");
                $display("Test completed with failures");
                $finish;
            end
        join_any
        disable fork;
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("Covered %0d words over all opcodes, range ends and zero divisors;", accepted);
        $display("%0d results checked with random stalls on both channels.", board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
